// ===== rtl/bary_pkg.sv =====
package bary_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIFF_W     = COORD_BITS + 1;   // signed vertex/pixel difference
  localparam int PROD_W     = 2 * DIFF_W;       // signed coordinate product
  localparam int DOT_W      = PROD_W + 1;       // signed dot product
  localparam int WIDE_W     = 2 * DOT_W;        // signed product of dot products
  localparam int NUM_W      = WIDE_W + 1;       // signed divider / numerators
  localparam int MAG_W      = NUM_W - 1;        // magnitude once normalized
  localparam int COLOR_W    = 8;
  localparam int COLOR_MAX  = (1 << COLOR_W) - 1;
  localparam int REM_W      = MAG_W + COLOR_W;  // holds 255 * numerator

  localparam int NLANE      = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_A_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_A_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_B_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_C_X = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_C_Y = CFG_IDX_W'(5);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
  } verts_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] uu;
    logic signed [DOT_W-1:0] vv;
    logic signed [DOT_W-1:0] uv;
    logic signed [DOT_W-1:0] wu;
    logic signed [DOT_W-1:0] wv;
  } dot_t;

  typedef struct packed {
    logic             hit;
    logic [MAG_W-1:0] d;
    logic [MAG_W-1:0] ns;
    logic [MAG_W-1:0] nt;
    logic [MAG_W-1:0] nb;
  } weight_t;

  typedef struct packed {
    logic                           hit;
    logic [NLANE-1:0][COLOR_W-1:0]  q;
  } color_t;

  function automatic logic signed [DIFF_W-1:0] coord_diff(input logic [COORD_BITS-1:0] a,
                                                          input logic [COORD_BITS-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

endpackage

// ===== rtl/bary_dot.sv =====
module bary_dot (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bary_pkg::point_t in_pix,
  input  bary_pkg::verts_t verts,
  output logic             out_valid,
  input  logic             out_ready,
  output bary_pkg::dot_t   out_dot
);
  import bary_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  // stage 0: edge vectors from vertex c
  logic signed [DIFF_W-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r;
  // stage 1: coordinate products
  logic signed [PROD_W-1:0] sq_ux_r, sq_uy_r, sq_vx_r, sq_vy_r;
  logic signed [PROD_W-1:0] m_uv_x_r, m_uv_y_r, m_wu_x_r, m_wu_y_r, m_wv_x_r, m_wv_y_r;
  // stage 2: dot products
  dot_t dot_r;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux_r <= coord_diff(verts.a.x, verts.c.x);
      uy_r <= coord_diff(verts.a.y, verts.c.y);
      vx_r <= coord_diff(verts.b.x, verts.c.x);
      vy_r <= coord_diff(verts.b.y, verts.c.y);
      wx_r <= coord_diff(in_pix.x, verts.c.x);
      wy_r <= coord_diff(in_pix.y, verts.c.y);
    end
    if (en[1]) begin
      sq_ux_r  <= PROD_W'(ux_r) * PROD_W'(ux_r);
      sq_uy_r  <= PROD_W'(uy_r) * PROD_W'(uy_r);
      sq_vx_r  <= PROD_W'(vx_r) * PROD_W'(vx_r);
      sq_vy_r  <= PROD_W'(vy_r) * PROD_W'(vy_r);
      m_uv_x_r <= PROD_W'(ux_r) * PROD_W'(vx_r);
      m_uv_y_r <= PROD_W'(uy_r) * PROD_W'(vy_r);
      m_wu_x_r <= PROD_W'(wx_r) * PROD_W'(ux_r);
      m_wu_y_r <= PROD_W'(wy_r) * PROD_W'(uy_r);
      m_wv_x_r <= PROD_W'(wx_r) * PROD_W'(vx_r);
      m_wv_y_r <= PROD_W'(wy_r) * PROD_W'(vy_r);
    end
    if (en[2]) begin
      dot_r.uu <= DOT_W'(sq_ux_r) + DOT_W'(sq_uy_r);
      dot_r.vv <= DOT_W'(sq_vx_r) + DOT_W'(sq_vy_r);
      dot_r.uv <= DOT_W'(m_uv_x_r) + DOT_W'(m_uv_y_r);
      dot_r.wu <= DOT_W'(m_wu_x_r) + DOT_W'(m_wu_y_r);
      dot_r.wv <= DOT_W'(m_wv_x_r) + DOT_W'(m_wv_y_r);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_dot   = dot_r;

endmodule

// ===== rtl/bary_solve.sv =====
module bary_solve (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bary_pkg::dot_t    in_dot,
  output logic              out_valid,
  input  logic              out_ready,
  output bary_pkg::weight_t out_wgt
);
  import bary_pkg::*;

  localparam int NS = 4;
  localparam int SUM_W = NUM_W + 2;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic signed [WIDE_W-1:0] uvuv_r, uuvv_r, wvuv_r, wuvv_r, wuuv_r, wvuu_r;
  logic signed [NUM_W-1:0]  d_r, ns_r, nt_r;
  logic signed [NUM_W-1:0]  dn_r, nsn_r, ntn_r;
  logic signed [SUM_W-1:0]  nb;
  logic                     hit;
  weight_t                  wgt_r;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // blue weight numerator; ns + nt < d is the same as nb > 0
  assign nb = SUM_W'(dn_r) - SUM_W'(nsn_r) - SUM_W'(ntn_r);
  assign hit = (dn_r != '0) && (nsn_r > 0) && (ntn_r > 0) &&
               (nsn_r < dn_r) && (ntn_r < dn_r) && (nb > 0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      uvuv_r <= WIDE_W'($signed(in_dot.uv)) * WIDE_W'($signed(in_dot.uv));
      uuvv_r <= WIDE_W'($signed(in_dot.uu)) * WIDE_W'($signed(in_dot.vv));
      wvuv_r <= WIDE_W'($signed(in_dot.wv)) * WIDE_W'($signed(in_dot.uv));
      wuvv_r <= WIDE_W'($signed(in_dot.wu)) * WIDE_W'($signed(in_dot.vv));
      wuuv_r <= WIDE_W'($signed(in_dot.wu)) * WIDE_W'($signed(in_dot.uv));
      wvuu_r <= WIDE_W'($signed(in_dot.wv)) * WIDE_W'($signed(in_dot.uu));
    end
    if (en[1]) begin
      d_r  <= NUM_W'(uvuv_r) - NUM_W'(uuvv_r);
      ns_r <= NUM_W'(wvuv_r) - NUM_W'(wuvv_r);
      nt_r <= NUM_W'(wuuv_r) - NUM_W'(wvuu_r);
    end
    // flip signs so the divider is non-negative
    if (en[2]) begin
      dn_r  <= d_r[NUM_W-1] ? -d_r  : d_r;
      nsn_r <= d_r[NUM_W-1] ? -ns_r : ns_r;
      ntn_r <= d_r[NUM_W-1] ? -nt_r : nt_r;
    end
    if (en[3]) begin
      wgt_r.hit <= hit;
      wgt_r.d   <= dn_r[MAG_W-1:0];
      wgt_r.ns  <= nsn_r[MAG_W-1:0];
      wgt_r.nt  <= ntn_r[MAG_W-1:0];
      wgt_r.nb  <= nb[MAG_W-1:0];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_wgt   = wgt_r;

`ifndef NO_ASSERTIONS
  a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && wgt_r.hit |->
      (MAG_W+2)'(wgt_r.ns) + (MAG_W+2)'(wgt_r.nt) + (MAG_W+2)'(wgt_r.nb) ==
      (MAG_W+2)'(wgt_r.d))
    else $error("weight numerators do not add up to the divider");
`endif

endmodule

// ===== rtl/bary_div.sv =====
module bary_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bary_pkg::weight_t in_wgt,
  output logic              out_valid,
  input  logic              out_ready,
  output bary_pkg::color_t  out_color
);
  import bary_pkg::*;

  // one setup stage, then one quotient bit per stage, MSB first
  localparam int NS = COLOR_W + 1;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic [MAG_W-1:0]   d_r   [NS];
  logic [NS-1:0]      ins_r;
  logic [REM_W-1:0]   r_r   [NS][NLANE];
  logic [COLOR_W-1:0] q_r   [NS][NLANE];
  logic [MAG_W-1:0]   num   [NLANE];
  logic [REM_W-1:0]   r_nxt [COLOR_W][NLANE];
  logic [COLOR_W-1:0] q_nxt [COLOR_W][NLANE];

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_comb begin
    num[LANE_RED]   = in_wgt.ns;
    num[LANE_GREEN] = in_wgt.nt;
    num[LANE_BLUE]  = in_wgt.nb;
  end

  // restoring step: compare remainder with d shifted to the current bit
  always_comb begin
    logic [REM_W-1:0] dsh;
    logic             ge;
    dsh = '0;
    ge  = 1'b0;
    for (int k = 0; k < COLOR_W; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        dsh = REM_W'(d_r[k]) << (COLOR_W - 1 - k);
        ge  = r_r[k][l] >= dsh;
        r_nxt[k][l] = ge ? r_r[k][l] - dsh : r_r[k][l];
        q_nxt[k][l] = {q_r[k][l][COLOR_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0]   <= in_wgt.d;
      ins_r[0] <= in_wgt.hit;
      for (int l = 0; l < NLANE; l++) begin
        // 255 * n
        r_r[0][l] <= (REM_W'(num[l]) << COLOR_W) - REM_W'(num[l]);
        q_r[0][l] <= '0;
      end
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        d_r[k]   <= d_r[k-1];
        ins_r[k] <= ins_r[k-1];
        for (int l = 0; l < NLANE; l++) begin
          r_r[k][l] <= r_nxt[k-1][l];
          q_r[k][l] <= q_nxt[k-1][l];
        end
      end
    end
  end

  always_comb begin
    out_color.hit = ins_r[NS-1];
    for (int l = 0; l < NLANE; l++) begin
      out_color.q[l] = q_r[NS-1][l];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

`ifndef NO_ASSERTIONS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && ins_r[NS-1] |->
      (r_r[NS-1][LANE_RED] < REM_W'(d_r[NS-1])) &&
      (r_r[NS-1][LANE_GREEN] < REM_W'(d_r[NS-1])) &&
      (r_r[NS-1][LANE_BLUE] < REM_W'(d_r[NS-1])))
    else $error("final remainder not below divider");
`endif

endmodule

// ===== rtl/triangle_barycentric_pixel_shader.sv =====
// Barycentric pixel test: vertices a, b and c are loaded through the cfg word port
// (index 0..5 = a.x, a.y, b.x, b.y, c.x, c.y; other indexes are dropped; cfg_ready is
// always high) and may only change while no pixel is in flight. Each input word is one
// pixel; each output word says whether the pixel lies strictly inside the triangle and
// gives floor(255*s), floor(255*t), floor(255*(1-s-t)) as red, green, blue (all zero when
// outside or when the triangle is degenerate). Fully pipelined: one pixel per clock without
// backpressure, through 3 dot-product, 4 solve and 9 divider stages (a setup stage, then one
// quotient bit per stage) and the output register. Each stage stalls only when it is full and
// the stage after it cannot move, so bubbles are squeezed out under backpressure.
module triangle_barycentric_pixel_shader (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bary_pkg::COORD_BITS-1:0]    in_pixel_x,
  input  logic [bary_pkg::COORD_BITS-1:0]    in_pixel_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_inside_res,
  output logic [bary_pkg::COLOR_W-1:0]       out_red,
  output logic [bary_pkg::COLOR_W-1:0]       out_green,
  output logic [bary_pkg::COLOR_W-1:0]       out_blue,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bary_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bary_pkg::COORD_BITS-1:0]    cfg_data
);
  import bary_pkg::*;

  verts_t  verts_r;
  point_t  pix;
  logic    dot_valid, dot_ready;
  dot_t    dot;
  logic    wgt_valid, wgt_ready;
  weight_t wgt;
  logic    div_valid, div_ready;
  color_t  col;

  logic               out_valid_r;
  logic               inside_r;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  logic               out_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verts_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_A_X: verts_r.a.x <= cfg_data;
        REG_A_Y: verts_r.a.y <= cfg_data;
        REG_B_X: verts_r.b.x <= cfg_data;
        REG_B_Y: verts_r.b.y <= cfg_data;
        REG_C_X: verts_r.c.x <= cfg_data;
        REG_C_Y: verts_r.c.y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pix.x = in_pixel_x;
    pix.y = in_pixel_y;
  end

  bary_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (pix),
    .verts     (verts_r),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .out_dot   (dot)
  );

  bary_solve u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dot_valid),
    .in_ready  (dot_ready),
    .in_dot    (dot),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_wgt   (wgt)
  );

  bary_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_wgt    (wgt),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_color (col)
  );

  // output register; colors forced to zero for pixels outside
  assign out_en    = !out_valid_r || out_ready;
  assign div_ready = out_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && div_valid) begin
      inside_r <= col.hit;
      red_r    <= col.hit ? col.q[LANE_RED]   : '0;
      green_r  <= col.hit ? col.q[LANE_GREEN] : '0;
      blue_r   <= col.hit ? col.q[LANE_BLUE]  : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;

`ifndef NO_ASSERTIONS
  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |->
      (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("color on a pixel outside the triangle");

  a_color_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |->
      ((COLOR_W+2)'(out_red) + (COLOR_W+2)'(out_green) + (COLOR_W+2)'(out_blue) <=
       (COLOR_W+2)'(COLOR_MAX)) &&
      ((COLOR_W+2)'(out_red) + (COLOR_W+2)'(out_green) + (COLOR_W+2)'(out_blue) >=
       (COLOR_W+2)'(COLOR_MAX - 2)))
    else $error("color weights do not sum to full scale");

  a_div_held: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid && !div_ready |=> div_valid)
    else $error("divider result dropped while output stalled");
`endif

endmodule
